FILE: rtl/core/iirdf2_pkg.sv
package iirdf2_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 16;
    localparam int WORD_W    = 24;
    localparam int PROD_W    = COEF_W + WORD_W;
    localparam int ACC_W     = PROD_W + 6;
    localparam int FRAC_DROP = 12;
    localparam int RND_W     = ACC_W - FRAC_DROP;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int TAP_IDX_W = 5;   // covers taps 0..31

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FF_LO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_HI = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HI = 2'd3;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [WORD_W-1:0]   word_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [CFG_W-1:0]           cfg_t;
    typedef logic [TAP_IDX_W-1:0]       tap_t;

    typedef struct packed {
        logic    clear;   // load accumulators with the new sample
        logic    issue;   // multiply tap coefficients by the chain word
        logic    load_w;  // multiply b0 by the new state word
    } mac_ctrl_t;

    localparam acc_t ACC_HALF = acc_t'(2048);

    function automatic coef_t lane(cfg_t r, logic [1:0] k);
        coef_t c;
        case (k)
            2'd0:    c = r[15:0];
            2'd1:    c = r[31:16];
            2'd2:    c = r[47:32];
            default: c = r[63:48];
        endcase
        return c;
    endfunction

    // b_i; zero beyond b6
    function automatic coef_t coef_b(cfg_t lo, cfg_t hi, tap_t i);
        coef_t c;
        case (i)
            5'd0, 5'd1, 5'd2, 5'd3: c = lane(lo, i[1:0]);
            5'd4, 5'd5, 5'd6:       c = lane(hi, 2'(i - 5'd4));
            default:                c = '0;
        endcase
        return c;
    endfunction

    // a_i; a0 unused, zero beyond a6
    function automatic coef_t coef_a(cfg_t lo, cfg_t hi, tap_t i);
        coef_t c;
        case (i)
            5'd1, 5'd2, 5'd3, 5'd4: c = lane(lo, 2'(i - 5'd1));
            5'd5, 5'd6:             c = lane(hi, 2'(i - 5'd5));
            default:                c = '0;
        endcase
        return c;
    endfunction

    // round half up, drop 12 fraction bits (floor)
    function automatic logic signed [RND_W-1:0] round12(acc_t v);
        acc_t t;
        t = v + ACC_HALF;
        return signed'(t[ACC_W-1:FRAC_DROP]);
    endfunction

    function automatic word_t sat_word(acc_t v);
        logic signed [RND_W-1:0] r;
        word_t o;
        r = round12(v);
        if (!r[RND_W-1] && (|r[RND_W-2:WORD_W-1]))
            o = {1'b0, {(WORD_W-1){1'b1}}};
        else if (r[RND_W-1] && !(&r[RND_W-2:WORD_W-1]))
            o = {1'b1, {(WORD_W-1){1'b0}}};
        else
            o = r[WORD_W-1:0];
        return o;
    endfunction

    function automatic sample_t sat_sample(acc_t v);
        logic signed [RND_W-1:0] r;
        sample_t o;
        r = round12(v);
        if (!r[RND_W-1] && (|r[RND_W-2:SAMPLE_W-1]))
            o = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (r[RND_W-1] && !(&r[RND_W-2:SAMPLE_W-1]))
            o = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            o = r[SAMPLE_W-1:0];
        return o;
    endfunction

endpackage

FILE: rtl/core/iirdf2_cell.sv
// One delay-line cell: holds a state word, takes its neighbor's on shift.
module iirdf2_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                shift_en,
    input  iirdf2_pkg::word_t   word_in,
    output iirdf2_pkg::word_t   word_out
);
    import iirdf2_pkg::*;

    word_t word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (shift_en)
        begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: rtl/core/iirdf2_mac.sv
// Shared multiply-accumulate: feedback sum in acc_a, feedforward sum in acc_b.
module iirdf2_mac (
    input  logic                    clk,
    input  logic                    rst_n,
    input  iirdf2_pkg::mac_ctrl_t   ctrl,
    input  iirdf2_pkg::sample_t     x,
    input  iirdf2_pkg::coef_t       ca,
    input  iirdf2_pkg::coef_t       cb,
    input  iirdf2_pkg::word_t       word,
    output iirdf2_pkg::word_t       w,
    output iirdf2_pkg::sample_t     y
);
    import iirdf2_pkg::*;

    prod_t prod_a_reg;
    prod_t prod_b_reg;
    logic  prod_vld_reg;
    acc_t  acc_a_reg;
    acc_t  acc_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctrl.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.issue)
        begin
            prod_a_reg <= prod_t'(ca) * prod_t'(word);
            prod_b_reg <= prod_t'(cb) * prod_t'(word);
        end
        else if (ctrl.load_w)
        begin
            prod_b_reg <= prod_t'(cb) * prod_t'(w);
        end

        if (ctrl.clear)
        begin
            acc_a_reg <= acc_t'(x) <<< FRAC_DROP;
            acc_b_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_a_reg <= acc_a_reg - acc_t'(prod_a_reg);
            acc_b_reg <= acc_b_reg + acc_t'(prod_b_reg);
        end
    end

    assign w = sat_word(acc_a_reg);
    assign y = sat_sample(acc_b_reg + acc_t'(prod_b_reg));

endmodule

FILE: rtl/core/iir_direct_form_two_filter.sv
// Sixth-order (ORDER taps) direct form II IIR filter for Q1.15 samples with
// Q4.12 coefficients and a saturating 24-bit Q9.15 state. The state words sit in
// a ring of ORDER cells; for each sample the ring rotates once past a single shared
// multiply-accumulate unit that forms the feedback and feedforward sums together.
// On acceptance the accumulators take the sample; until s_tready rises again the word
// goes through the ring rotation through the multipliers (S_MAC), a drain of the
// product register (S_DRAIN), the forming of the new state word and its shift into
// the ring (S_WORD), and the rounding of the output into the output register (S_OUT).
// The output register lets a new word be accepted while a result waits on m_tready.
// Coefficients: cfg_addr 0 = b0..b3, 1 = b4..b6, 2 = a1..a4, 3 = a5..a6, lane k in
// bits 16k+15:16k; write them only while the filter is idle. s_tlast is passed
// through to m_tlast and does not clear the state.
module iir_direct_form_two_filter #(
    parameter int ORDER = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // coefficient writes
    input  logic                            cfg_we,
    input  logic [iirdf2_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  iirdf2_pkg::cfg_t                cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // [15:0] sample_in
    input  logic                            s_tlast,   // block_end_in
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // [15:0] sample_out
    output logic                            m_tlast    // block_end_out
);
    import iirdf2_pkg::*;

    localparam int CNT_W = $clog2(ORDER + 1);
    localparam logic [CNT_W-1:0] ORDER_L   = CNT_W'(ORDER);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ORDER - 1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_WORD  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    // coefficient registers
    cfg_t ff_lo_reg, ff_hi_reg, fb_lo_reg, fb_hi_reg;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg;

    logic             out_vld_reg, out_vld_next;
    sample_t          out_data_reg;
    logic             out_last_reg;

    logic             accept;
    logic             rotate;
    logic             shift_in;
    logic             out_load;
    mac_ctrl_t        mac_ctrl;
    tap_t             tap;
    coef_t            ca, cb;
    word_t            w_new;
    sample_t          y_new;

    word_t            chain_in  [ORDER];
    word_t            chain_out [ORDER];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ff_lo_reg <= '0;
            ff_hi_reg <= '0;
            fb_lo_reg <= '0;
            fb_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FF_LO: ff_lo_reg <= cfg_data;
                REG_FF_HI: ff_hi_reg <= cfg_data;
                REG_FB_LO: fb_lo_reg <= cfg_data;
                REG_FB_HI: fb_hi_reg <= cfg_data;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign rotate   = (state_reg == S_MAC);
    assign shift_in = (state_reg == S_WORD);
    assign out_load = (state_reg == S_OUT) && (!out_vld_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                cnt_next = cnt_reg + CNT_ONE;
                if (cnt_reg == LAST_STEP)
                    state_next = S_DRAIN;
            end
            S_DRAIN: state_next = S_WORD;
            S_WORD:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            last_reg <= s_tlast;
    end

    // the oldest cell faces the multipliers; after k rotations it holds tap ORDER-k
    always_comb
    begin
        if (state_reg == S_WORD)
            tap = '0;
        else
            tap = TAP_IDX_W'(ORDER_L - cnt_reg);
        ca = coef_a(fb_lo_reg, fb_hi_reg, tap);
        cb = coef_b(ff_lo_reg, ff_hi_reg, tap);
    end

    always_comb
    begin
        mac_ctrl.clear  = accept;
        mac_ctrl.issue  = rotate;
        mac_ctrl.load_w = shift_in;
    end

    iirdf2_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .x     (sample_t'(s_tdata)),
        .ca    (ca),
        .cb    (cb),
        .word  (chain_out[ORDER-1]),
        .w     (w_new),
        .y     (y_new)
    );

    // ring: rotate closes the loop, shift_in feeds the new state word
    genvar g;
    generate
        for (g = 0; g < ORDER; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign chain_in[g] = shift_in ? w_new : chain_out[ORDER-1];
            end
            else
            begin : g_body
                assign chain_in[g] = chain_out[g-1];
            end

            iirdf2_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (rotate || shift_in),
                .word_in  (chain_in[g]),
                .word_out (chain_out[g])
            );
        end
    endgenerate

    // output register
    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (out_load)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= y_new;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // a result appears only from the output step
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("output valid without output step");

    // an accepted word starts the ring pass at step zero
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_MAC) && (cnt_reg == '0))
        else $error("ring pass did not start after accept");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) && m_tvalid && !m_tready |=> (state_reg == S_OUT))
        else $error("output step left while result stalled");

    // the ring pass takes exactly ORDER steps
    a_pass_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> $past(cnt_reg == LAST_STEP))
        else $error("ring pass length wrong");

endmodule

FILE: test/tb_iir_direct_form_two_filter.sv
module tb_iir_direct_form_two_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import iirdf2_pkg::*;

    localparam int    ORDER       = 6;
    localparam int    CYCLE_LIMIT = 600000;
    localparam int    TAIL_CYCLES = 40;
    localparam int    PHASES      = 12;
    localparam int    PHASE_WORDS = 128;
    localparam longint WORD_MAX   = 64'sd8388607;
    localparam longint WORD_MIN   = -64'sd8388608;

    // pacing of the two stream sides
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pace_e;

    // flavor of coefficient set loaded for a random phase
    typedef enum int {STYLE_DAMPED, STYLE_RANDOM, STYLE_RAIL, STYLE_RESONANT} coef_style_e;

    typedef struct packed {
        sample_t sample;
        logic    block_end;
    } filtered_t;

    // ------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = REG_FF_LO;
    cfg_t                 cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata  = '0;   // [15:0] sample_in
    logic                 s_tlast  = 1'b0; // block_end_in
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [15:0]          m_tdata;         // [15:0] sample_out
    logic                 m_tlast;         // block_end_out

    iir_direct_form_two_filter #(
        .ORDER(ORDER)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Filter predictor: own copy of coefficients and delay line
    // ------------------------------------------------------------------
    cfg_t      coef_regs [4] = '{default: '0};
    word_t     history [ORDER] = '{default: '0};   // entry 0 is the newest state word
    filtered_t expected_filtered [$];

    pace_e pace_mode        = IDLE_NONE;
    int    fail_count       = 0;
    int    words_sent       = 0;
    int    words_received   = 0;
    int    marks_sent       = 0;
    int    coef_sets_loaded = 0;
    int    drains           = 0;
    longint cycle_count     = 0;

    function automatic longint lane_value(cfg_t r, int k);
        return longint'($signed(r[16*k +: 16]));
    endfunction

    // b_i, zero past the last register lane
    function automatic longint ff_coef(int i);
        if (i < 4)
            return lane_value(coef_regs[REG_FF_LO], i);
        if (i < 7)
            return lane_value(coef_regs[REG_FF_HI], i - 4);
        return 0;
    endfunction

    // a_i for i >= 1; a0 is implicit unity
    function automatic longint fb_coef(int i);
        if (i >= 1 && i < 5)
            return lane_value(coef_regs[REG_FB_LO], i - 1);
        if (i >= 5 && i < 7)
            return lane_value(coef_regs[REG_FB_HI], i - 5);
        return 0;
    endfunction

    // round half up while dropping 12 fraction bits; >>> floors
    function automatic longint round_drop12(longint v);
        return (v + 2048) >>> 12;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // One sample through the filter: new state word, output, delay-line shift.
    function automatic filtered_t filter_step(sample_t x, logic last);
        filtered_t res;
        longint    acc;
        longint    w;
        int        i;
        acc = longint'(x) * 4096;
        for (i = 1; i <= ORDER; i++)
            acc -= fb_coef(i) * longint'(history[i-1]);
        w = clamp(round_drop12(acc), WORD_MIN, WORD_MAX);
        acc = ff_coef(0) * w;
        for (i = 1; i <= ORDER; i++)
            acc += ff_coef(i) * longint'(history[i-1]);
        res.sample    = sample_t'(clamp(round_drop12(acc), -32768, 32767));
        res.block_end = last;
        for (i = ORDER - 1; i > 0; i--)
            history[i] = history[i-1];
        history[0] = word_t'(w);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic bit roll_idle(bit sender_side);
        int pct;
        case (pace_mode)
            IDLE_SENDER:   pct = sender_side ? 82 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 82;
            IDLE_BOTH:     pct = 9;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    function automatic cfg_t pack4(coef_t c0, coef_t c1, coef_t c2, coef_t c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic coef_t small_coef(int span);
        return coef_t'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic coef_t rail_coef();
        case ($urandom_range(2))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'h0000;
        endcase
    endfunction

    // mostly full-range noise, with some quiet input and some rail hits
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1, 2:    return sample_t'(int'($urandom_range(512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Send one word. valid is not lowered after the handshake, so back-to-back words keep it high;
    // a gap lowers it only while the sender is idling.
    task automatic send_sample(input sample_t x, input logic last);
        while (roll_idle(1'b1))
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        expected_filtered.push_back(filter_step(x, last));
        words_sent++;
        if (last)
            marks_sent++;
    endtask

    // Hold the sender off until every pending output has been checked.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (expected_filtered.size() != 0);
        drains++;
    endtask

    // Load all four coefficient registers; caller guarantees the filter is idle.
    task automatic write_coefs(input cfg_t ff_lo, input cfg_t ff_hi,
                               input cfg_t fb_lo, input cfg_t fb_hi);
        logic [CFG_IDX_W-1:0] idx [4];
        cfg_t                 vals [4];
        int                   r;
        idx  = '{REG_FF_LO, REG_FF_HI, REG_FB_LO, REG_FB_HI};
        vals = '{ff_lo, ff_hi, fb_lo, fb_hi};
        for (r = 0; r < 4; r++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx[r];
            cfg_data <= vals[r];
            @(posedge clk);
            coef_regs[idx[r]] = vals[r];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        coef_sets_loaded++;
    endtask

    // ------------------------------------------------------------------
    // Output checker and receiver pacing
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_output
        filtered_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_received++;
            if (expected_filtered.size() == 0)
            begin
                $error("m_tdata: word %0d arrived with nothing pending", $signed(m_tdata));
                fail_count++;
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (m_tdata !== want.sample)
                begin
                    $error("sample_out: expected %0d, got %0d", want.sample, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tlast !== want.block_end)
                begin
                    $error("block_end_out: expected %0b, got %0b", want.block_end, m_tlast);
                    fail_count++;
                end
            end
        end
        m_tready <= !roll_idle(1'b0);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("iir_direct_form_two_filter verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // all coefficients come out of reset at zero, so full-scale input gives silence
    task automatic test_reset_state();
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
    endtask

    // b0 = 1.0, no feedback: output equals input. Junk in the unused upper lanes
    // must not leak into b4..b6 or a5..a6.
    task automatic test_unity_passthrough();
        wait_drained();
        write_coefs(pack4(16'h1000, 16'h0, 16'h0, 16'h0), 64'hABCD_0000_0000_0000,
                    64'h0, 64'hFFFF_FFFF_0000_0000);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
        send_sample(16'sd1, 1'b0);
    endtask

    // y = x + x[n-1]: the sample after a block mark still sees the previous one
    task automatic test_block_end_keeps_state();
        wait_drained();
        write_coefs(pack4(16'h1000, 16'h1000, 16'h0, 16'h0), 64'h0, 64'h0, 64'h0);
        send_sample(16'sd1000, 1'b1);
        send_sample(16'sd2000, 1'b0);
        send_sample(-16'sd3000, 1'b1);
        send_sample(16'sd4000, 1'b1);
    endtask

    // a1 near +8 (subtracted, so w[n] ~ x - 8 w[n-1]) makes the state alternate in
    // sign and grow, so it pins at both 24-bit rails; b0/b1 at the coefficient
    // extremes push the output to both rails
    task automatic test_saturation();
        int n;
        wait_drained();
        write_coefs(pack4(16'h7FFF, 16'h8000, 16'h0, 16'h0), 64'h0,
                    pack4(16'h7FFF, 16'h0, 16'h0, 16'h0), 64'h0);
        for (n = 0; n < 5; n++)
            send_sample(16'sh7FFF, n[0]);
        for (n = 0; n < 3; n++)
            send_sample(16'sh8000, 1'b0);
    endtask

    // Phases of random traffic, each with its own coefficient set and pacing.
    // Most words come in well-formed blocks; a few carry stray marks.
    task automatic test_random_traffic();
        coef_style_e style;
        cfg_t        ff_lo, ff_hi, fb_lo, fb_hi;
        int          p, n;
        int          left_in_block;
        logic        last;
        left_in_block = 0;
        for (p = 0; p < PHASES; p++)
        begin
            // coefficients only change with the pipe empty
            wait_drained();
            pace_mode = pace_e'(p % 4);
            style     = coef_style_e'((p + p / 4) % 4);
            case (style)
                STYLE_DAMPED:
                begin
                    // sum of |a_i| stays below one, so the state decays
                    ff_lo = pack4(small_coef(2048), small_coef(2048), small_coef(2048),
                                  small_coef(2048));
                    ff_hi = pack4(small_coef(2048), small_coef(2048), small_coef(2048),
                                  coef_t'($urandom));
                    fb_lo = pack4(small_coef(600), small_coef(600), small_coef(600),
                                  small_coef(600));
                    fb_hi = {$urandom, 16'(small_coef(600)), 16'(small_coef(600))};
                end
                STYLE_RANDOM:
                begin
                    ff_lo = {$urandom, $urandom};
                    ff_hi = {$urandom, $urandom};
                    fb_lo = {$urandom, $urandom};
                    fb_hi = {$urandom, $urandom};
                end
                STYLE_RAIL:
                begin
                    ff_lo = pack4(rail_coef(), rail_coef(), rail_coef(), rail_coef());
                    ff_hi = pack4(rail_coef(), rail_coef(), rail_coef(), rail_coef());
                    fb_lo = pack4(rail_coef(), rail_coef(), rail_coef(), rail_coef());
                    fb_hi = pack4(rail_coef(), rail_coef(), rail_coef(), rail_coef());
                end
                default:
                begin
                    // stable two-pole resonator, pole radius just under one
                    ff_lo = pack4(16'h0400, small_coef(512), small_coef(512), small_coef(512));
                    ff_hi = pack4(small_coef(512), small_coef(512), small_coef(512),
                                  coef_t'($urandom));
                    fb_lo = pack4(small_coef(7700), coef_t'(3700 + $urandom_range(300)),
                                  16'h0, 16'h0);
                    fb_hi = {$urandom, 32'h0};
                end
            endcase
            write_coefs(ff_lo, ff_hi, fb_lo, fb_hi);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (left_in_block == 0)
                    left_in_block = $urandom_range(24, 1);
                left_in_block--;
                last = (left_in_block == 0);
                if ($urandom_range(15) == 0)
                    last = ~last;
                send_sample(pick_sample(), last);
                // now and then let the output side empty out completely
                if ($urandom_range(63) == 0)
                    wait_drained();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_unity_passthrough();
        test_block_end_keeps_state();
        test_saturation();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d words (%0d block marks) across %0d coefficient sets,",
                 words_sent, marks_sent, coef_sets_loaded);
        $display("four pacing modes and %0d full drains; %0d words checked.",
                 drains, words_received);
        if (fail_count == 0)
            $display("iir_direct_form_two_filter verification clean");
        else
            $display("iir_direct_form_two_filter verification failed");
        $finish;
    end

endmodule

FILE: iir_direct_form_two_filter.f
rtl/core/iirdf2_pkg.sv
rtl/core/iirdf2_cell.sv
rtl/core/iirdf2_mac.sv
rtl/core/iir_direct_form_two_filter.sv
test/tb_iir_direct_form_two_filter.sv
